### design/sadst_pkg.sv
// sadst_pkg: request and status codes, default sizes and the
// controller/datapath handshake structs for the shared-array dual stack
// no dependencies
package sadst_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 16;

  // request codes, code 3 is unused and dropped without a result
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_LIST = 2'd2;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    latch_req;
    logic    push;
    logic    pop;
    logic    list_start;
    logic    list_next;
    logic    load_out;
    logic    out_from_mem;
    status_t out_status;
    logic    out_last;
  } sadst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       empty;
    logic       list_last;
  } sadst_sts_t;

endpackage

### design/sadst_if.sv
// sadst_req_if and sadst_rsp_if: valid/ready channels for requests and results
// depends on sadst_pkg for the default data width
interface sadst_req_if #(
  parameter int DATA_WIDTH = sadst_pkg::DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic                         side;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, req_type, side, value, input ready);
  modport sink   (input valid, req_type, side, value, output ready);
endinterface

interface sadst_rsp_if #(
  parameter int DATA_WIDTH = sadst_pkg::DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] data;
  logic [1:0]                   status;
  logic                         last;

  modport source (output valid, data, status, last, input ready);
  modport sink   (input valid, data, status, last, output ready);
endinterface

### design/sadst_ctrl.sv
// sadst_ctrl: sequencing state machine for one request at a time
// depends on sadst_pkg
module sadst_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  sadst_pkg::sadst_sts_t sts,
  output sadst_pkg::sadst_cmd_t cmd
);
  import sadst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.out_status = ST_OK;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_RUN;
        end
      end
      S_RUN: begin
        case (sts.req)
          REQ_PUSH: begin
            if (out_free) begin
              cmd.load_out   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.push       = !sts.full;
              cmd.out_status = sts.full ? ST_OVERFLOW : ST_OK;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end
          end
          REQ_POP, REQ_LIST: begin
            if (sts.empty) begin
              if (out_free) begin
                cmd.load_out   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = (sts.req == REQ_POP) ? ST_UNDERFLOW : ST_EMPTY;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_IDLE;
              end
            end else begin
              cmd.pop        = (sts.req == REQ_POP);
              cmd.list_start = (sts.req == REQ_LIST);
              state_nxt      = S_READ;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        // read data is held until the output slot frees up
        if (out_free) begin
          cmd.load_out     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_status   = ST_OK;
          cmd.out_last     = (sts.req == REQ_POP) || sts.list_last;
          out_valid_nxt    = 1'b1;
          if (cmd.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.list_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/sadst_dp.sv
// sadst_dp: shared stack memory, stack counts, list index and result register
// depends on sadst_pkg
module sadst_dp #(
  parameter int DEPTH      = sadst_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sadst_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_req_type,
  input  logic                         in_side,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic signed [DATA_WIDTH-1:0] out_data,
  output logic [1:0]                   out_status,
  output logic                         out_last,
  input  sadst_pkg::sadst_cmd_t        cmd,
  output sadst_pkg::sadst_sts_t        sts
);
  import sadst_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [1:0]            req_r;
  logic                  side_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [CW-1:0]         left_cnt_r, left_cnt_nxt;
  logic [CW-1:0]         right_cnt_r, right_cnt_nxt;
  logic [AW-1:0]         idx_r;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic [1:0]            out_status_r;
  logic                  out_last_r;

  logic [CW-1:0]   cnt_sel;
  logic [CW:0]     cnt_sum;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   list_idx;
  logic            rd_en;

  assign cnt_sel = (side_r == SIDE_RIGHT) ? right_cnt_r : left_cnt_r;
  assign cnt_sum = {1'b0, left_cnt_r} + {1'b0, right_cnt_r};

  assign sts.req       = req_r;
  assign sts.full      = (cnt_sum >= {1'b0, DEPTH_C});
  assign sts.empty     = (cnt_sel == '0);
  assign sts.list_last = ((CW'(idx_r) + CW'(1)) == cnt_sel);

  assign wr_addr = (side_r == SIDE_RIGHT) ? (TOP_ADDR - AW'(right_cnt_r)) : AW'(left_cnt_r);

  // list walks bottom to top, pop reads the entry just released
  assign list_idx = cmd.list_start ? '0 : (idx_r + AW'(1));
  assign rd_en    = cmd.pop || cmd.list_start || cmd.list_next;

  always_comb begin
    if (cmd.pop) begin
      rd_addr = (side_r == SIDE_RIGHT) ? AW'(DEPTH_C - right_cnt_r)
                                       : AW'(left_cnt_r - CW'(1));
    end else begin
      rd_addr = (side_r == SIDE_RIGHT) ? (TOP_ADDR - list_idx) : list_idx;
    end
  end

  always_comb begin
    left_cnt_nxt  = left_cnt_r;
    right_cnt_nxt = right_cnt_r;
    if (cmd.push) begin
      if (side_r == SIDE_RIGHT) begin
        right_cnt_nxt = right_cnt_r + CW'(1);
      end else begin
        left_cnt_nxt = left_cnt_r + CW'(1);
      end
    end else if (cmd.pop) begin
      if (side_r == SIDE_RIGHT) begin
        right_cnt_nxt = right_cnt_r - CW'(1);
      end else begin
        left_cnt_nxt = left_cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_cnt_r  <= '0;
      right_cnt_r <= '0;
    end else begin
      left_cnt_r  <= left_cnt_nxt;
      right_cnt_r <= right_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_r   <= in_req_type;
      side_r  <= in_side;
      value_r <= in_value;
    end
    if (cmd.list_start || cmd.list_next) begin
      idx_r <= list_idx;
    end
    if (cmd.load_out) begin
      out_data_r   <= cmd.out_from_mem ? rdata_r : '0;
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
    end
  end

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= value_r;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

### design/shared_array_dual_stack_top.sv
// shared_array_dual_stack_top: two stacks sharing one memory, top level
// depends on sadst_pkg, sadst_if, sadst_ctrl and sadst_dp
//
// Two stacks live in one memory of DEPTH words: the left stack grows up from
// entry 0, the right stack grows down from entry DEPTH-1. Each request names
// push, pop or list and a side. Push and pop each give one result with last
// set; a push that finds both stacks together holding DEPTH words reports
// overflow, a pop of an empty side reports underflow, and neither changes
// anything. A list gives the side's words bottom to top with last on the top
// word, or a single list-empty result. Unused request codes give no result.
// One request is worked at a time. A pop makes one read of the memory; a
// list reads its words through the single registered read port of the
// memory, one word per cycle while the result side takes them. A finished
// result sits in an output register, so the next request is taken while it
// waits. Stalls on the result side hold the sequence without loss. No
// clearing pass is needed after reset: only entries below a stack's count
// are ever read.
module shared_array_dual_stack_top #(
  parameter int DEPTH      = sadst_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sadst_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sadst_req_if.sink   in_ch,
  sadst_rsp_if.source out_ch
);
  import sadst_pkg::*;

  // command and status between sequencer and datapath
  sadst_cmd_t cmd;
  sadst_sts_t sts;

  sadst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // memory, counts and the result register
  sadst_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req_type (in_ch.req_type),
    .in_side     (in_ch.side),
    .in_value    (in_ch.value),
    .out_data    (out_ch.data),
    .out_status  (out_ch.status),
    .out_last    (out_ch.last),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
